[hdl/wrzc_pkg.sv]
package wrzc_pkg;

    localparam int SAMPLE_BITS = 16;                 // width of one channel sample
    localparam int MONO_W      = SAMPLE_BITS + 1;    // sum of two channels
    localparam int MAG_W       = SAMPLE_BITS + 1;    // magnitude of the channel sum
    localparam int SQ_W        = 2 * MAG_W - 1;      // square of the magnitude
    localparam int SUM_W       = 47;                 // window sum of squares
    localparam int CNT_W       = 16;                 // sample and crossing counters
    localparam int LEVEL_W     = 16;                 // rms, rate and peak fields
    localparam int MEAN_W      = 2 * SAMPLE_BITS - 1; // mean square fits below 2^30 + 1
    localparam int RAD_W       = 2 * LEVEL_W;        // radicand of the root unit
    localparam int REM_W       = LEVEL_W + 1;        // partial remainder of the root unit

    localparam int IN_W   = 2 * SAMPLE_BITS;         // tdata of the input stream
    localparam int USER_W = 1;                       // tuser of the input stream
    localparam int OUT_W  = 3 * LEVEL_W;             // tdata of the output stream

    localparam int WIN_W  = 16;
    localparam int CHN_W  = 2;
    localparam int CFG_W  = 16;                      // widest register
    localparam int ADDR_W = 1;

    localparam logic [ADDR_W-1:0] REG_WINDOW_LENGTH = 1'b0;
    localparam logic [ADDR_W-1:0] REG_CHANNEL_COUNT = 1'b1;

    localparam logic [WIN_W-1:0] WINDOW_LENGTH_RESET = 16'd1024;
    localparam logic [CHN_W-1:0] CHANNEL_COUNT_RESET = 2'd1;

    localparam int MUL_STEPS  = MAG_W;               // one multiplier bit a cycle
    localparam int DIV_STEPS  = SUM_W;               // one quotient bit a cycle
    localparam int SQRT_STEPS = LEVEL_W;             // one root bit a cycle
    localparam int STEP_W     = 6;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_ACC,
        ST_DIV_MEAN,
        ST_DIV_RATE,
        ST_SQRT,
        ST_OUT
    } state_t;

endpackage

[hdl/windowed_rms_zero_crossing_unit.sv]
// An item that closes no window is accepted, squared by bit-serial shift-add and
// accumulated; an item that closes a window adds two passes of the shared restoring
// division (mean square, then crossing rate) and a digit-by-digit root, and its
// result then waits for a free output slot. No new item is taken until idle again.
// Reset (rst_n low, asynchronous): window length 1024, one channel, all sums,
// counters, previous sign and peak cleared, no result pending.
module windowed_rms_zero_crossing_unit
(
    input  logic                          clk,
    input  logic                          rst_n,
    // input stream
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [wrzc_pkg::IN_W-1:0]     s_tdata,  // sample_first, sample_second
    input  logic [wrzc_pkg::USER_W-1:0]   s_tuser,  // start_of_clip
    // result stream
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [wrzc_pkg::OUT_W-1:0]    m_tdata,  // rms_level, crossing_rate, peak_rms
    // configuration writes
    input  logic                          cfg_we,
    input  logic [wrzc_pkg::ADDR_W-1:0]   cfg_addr,
    input  logic [wrzc_pkg::CFG_W-1:0]    cfg_wdata
);
    import wrzc_pkg::*;

    // ---------------------------------------------------------------
    // Registers
    // ---------------------------------------------------------------
    state_t state_reg, state_next;

    logic [WIN_W-1:0]   window_length_reg;
    logic [CHN_W-1:0]   channel_count_reg;

    // window state
    logic [SUM_W-1:0]   square_sum_reg;
    logic [CNT_W-1:0]   sample_count_reg;
    logic [CNT_W-1:0]   crossing_count_reg;
    logic               prev_neg_reg;
    logic [LEVEL_W-1:0] peak_level_reg;

    // output slot
    logic               m_tvalid_reg;
    logic [OUT_W-1:0]   m_tdata_reg;

    // per-item scratch
    logic               two_reg;
    logic               window_done_reg;
    logic [STEP_W-1:0]  step_reg;
    logic [MAG_W-1:0]   mcand_reg;
    logic [MAG_W-1:0]   mplier_reg;
    logic [SQ_W-1:0]    prod_reg;
    logic [CNT_W-1:0]   div_rem_reg;
    logic [SUM_W-1:0]   div_quo_reg;
    logic [RAD_W-1:0]   rad_reg;
    logic [REM_W-1:0]   sq_rem_reg;
    logic [LEVEL_W-1:0] root_reg;
    logic [LEVEL_W-1:0] rate_reg;

    // ---------------------------------------------------------------
    // Accept-time arithmetic: mono value, sign change, counters
    // ---------------------------------------------------------------
    logic                     s_xfer;
    logic                     clip_start;
    logic                     two_ch;
    logic signed [MONO_W-1:0] mono;
    logic signed [MONO_W:0]   mono_neg;
    logic [MAG_W-1:0]         mono_mag;
    logic                     mono_neg_flag;
    logic [CNT_W-1:0]         cnt_base;
    logic [CNT_W-1:0]         cross_base;
    logic                     prev_base;
    logic [CNT_W-1:0]         cnt_new;
    logic [CNT_W-1:0]         cross_new;
    logic [WIN_W-1:0]         limit;
    logic                     done_new;

    assign s_xfer     = s_tvalid && s_tready;
    assign clip_start = s_tuser[0];
    assign two_ch     = channel_count_reg[1];
    assign limit      = (window_length_reg == '0) ? WIN_W'(1) : window_length_reg;

    always_comb
    begin
        mono = MONO_W'($signed(s_tdata[SAMPLE_BITS-1:0]));
        if (two_ch)
        begin
            mono = mono + MONO_W'($signed(s_tdata[IN_W-1:SAMPLE_BITS]));
        end
        mono_neg_flag = mono[MONO_W-1];
        mono_neg      = -($signed({mono[MONO_W-1], mono}));
        mono_mag      = mono_neg_flag ? mono_neg[MAG_W-1:0] : mono[MAG_W-1:0];

        // start of clip clears the window before this sample counts
        cnt_base   = clip_start ? '0 : sample_count_reg;
        cross_base = clip_start ? '0 : crossing_count_reg;
        prev_base  = clip_start ? 1'b0 : prev_neg_reg;

        cnt_new   = cnt_base + CNT_W'(1);
        cross_new = (mono_neg_flag != prev_base) ? cross_base + CNT_W'(1) : cross_base;
        done_new  = (cnt_new != '0) && (cnt_new >= limit);
    end

    // ---------------------------------------------------------------
    // Serial datapath steps
    // ---------------------------------------------------------------
    logic [SQ_W-1:0]    prod_step;
    logic [SQ_W-1:0]    sq_add;
    logic [SUM_W-1:0]   sum_new;
    logic [CNT_W:0]     div_trial;
    logic               div_bit;
    logic [CNT_W-1:0]   div_rem_step;
    logic [SUM_W-1:0]   div_quo_step;
    logic [REM_W+1:0]   sq_shift;
    logic [REM_W+1:0]   sq_trial;
    logic               sq_bit;
    logic [REM_W-1:0]   sq_rem_step;
    logic [LEVEL_W-1:0] root_step;
    logic [LEVEL_W-1:0] rate_sat;
    logic [LEVEL_W-1:0] peak_new;
    logic               last_step;

    always_comb
    begin
        // shift-add squaring, multiplier msb first
        prod_step = {prod_reg[SQ_W-2:0], 1'b0}
                  + (mplier_reg[MAG_W-1] ? SQ_W'(mcand_reg) : '0);

        // two channels keep floor(sum^2 / 4)
        sq_add  = two_reg ? (prod_reg >> 2) : prod_reg;
        sum_new = square_sum_reg + SUM_W'(sq_add);

        // restoring division by the sample count, one quotient bit a cycle
        div_trial    = {div_rem_reg, div_quo_reg[SUM_W-1]};
        div_bit      = div_trial >= {1'b0, sample_count_reg};
        div_rem_step = div_bit ? CNT_W'(div_trial - {1'b0, sample_count_reg})
                               : div_trial[CNT_W-1:0];
        div_quo_step = {div_quo_reg[SUM_W-2:0], div_bit};

        // digit-by-digit root, two radicand bits a cycle
        sq_shift    = {sq_rem_reg, rad_reg[RAD_W-1 -: 2]};
        sq_trial    = (REM_W+2)'({root_reg, 2'b01});
        sq_bit      = sq_shift >= sq_trial;
        sq_rem_step = sq_bit ? REM_W'(sq_shift - sq_trial) : sq_shift[REM_W-1:0];
        root_step   = {root_reg[LEVEL_W-2:0], sq_bit};

        // all crossings in the window give 65536: saturate
        rate_sat = (div_quo_step[SUM_W-1:LEVEL_W] != '0) ? '1 : div_quo_step[LEVEL_W-1:0];
        peak_new = (root_reg > peak_level_reg) ? root_reg : peak_level_reg;
    end

    // ---------------------------------------------------------------
    // Control: next state
    // ---------------------------------------------------------------
    logic slot_free;
    assign slot_free = !m_tvalid_reg || m_tready;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                if (last_step)
                begin
                    state_next = ST_ACC;
                end
            end
            ST_ACC:
            begin
                state_next = window_done_reg ? ST_DIV_MEAN : ST_IDLE;
            end
            ST_DIV_MEAN:
            begin
                if (last_step)
                begin
                    state_next = ST_DIV_RATE;
                end
            end
            ST_DIV_RATE:
            begin
                if (last_step)
                begin
                    state_next = ST_SQRT;
                end
            end
            ST_SQRT:
            begin
                if (last_step)
                begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (slot_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // ---------------------------------------------------------------
    // Control: outputs
    // ---------------------------------------------------------------
    logic out_load;

    always_comb
    begin
        s_tready  = 1'b0;
        out_load  = 1'b0;
        last_step = 1'b0;
        case (state_reg)
            ST_IDLE:     s_tready  = 1'b1;
            ST_MUL:      last_step = step_reg == STEP_W'(MUL_STEPS - 1);
            ST_DIV_MEAN: last_step = step_reg == STEP_W'(DIV_STEPS - 1);
            ST_DIV_RATE: last_step = step_reg == STEP_W'(DIV_STEPS - 1);
            ST_SQRT:     last_step = step_reg == STEP_W'(SQRT_STEPS - 1);
            ST_OUT:      out_load  = slot_free;
            default:     s_tready  = 1'b0;
        endcase
    end

    // ---------------------------------------------------------------
    // Control and window state
    // ---------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= ST_IDLE;
            window_length_reg  <= WINDOW_LENGTH_RESET;
            channel_count_reg  <= CHANNEL_COUNT_RESET;
            square_sum_reg     <= '0;
            sample_count_reg   <= '0;
            crossing_count_reg <= '0;
            prev_neg_reg       <= 1'b0;
            peak_level_reg     <= '0;
            m_tvalid_reg       <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_we)
            begin
                if (cfg_addr == REG_WINDOW_LENGTH)
                begin
                    window_length_reg <= cfg_wdata[WIN_W-1:0];
                end
                if (cfg_addr == REG_CHANNEL_COUNT)
                begin
                    channel_count_reg <= cfg_wdata[CHN_W-1:0];
                end
            end

            if (s_xfer)
            begin
                sample_count_reg   <= cnt_new;
                crossing_count_reg <= cross_new;
                prev_neg_reg       <= mono_neg_flag;
                if (clip_start)
                begin
                    square_sum_reg <= '0;
                    peak_level_reg <= '0;
                end
            end

            if (state_reg == ST_ACC)
            begin
                square_sum_reg <= sum_new;
            end

            // drop the window once its result takes the output slot
            if (out_load)
            begin
                peak_level_reg     <= peak_new;
                square_sum_reg     <= '0;
                sample_count_reg   <= '0;
                crossing_count_reg <= '0;
            end

            if (out_load)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // ---------------------------------------------------------------
    // Datapath scratch: shift registers of the serial units
    // ---------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                two_reg         <= two_ch;
                window_done_reg <= done_new;
                mcand_reg       <= mono_mag;
                mplier_reg      <= mono_mag;
                prod_reg        <= '0;
                step_reg        <= '0;
            end
            ST_MUL:
            begin
                prod_reg   <= prod_step;
                mplier_reg <= {mplier_reg[MAG_W-2:0], 1'b0};
                step_reg   <= step_reg + STEP_W'(1);
            end
            ST_ACC:
            begin
                // load the new window sum as dividend
                div_quo_reg <= sum_new;
                div_rem_reg <= '0;
                step_reg    <= '0;
            end
            ST_DIV_MEAN:
            begin
                if (last_step)
                begin
                    // hold the mean square, start the rate division
                    rad_reg     <= RAD_W'(div_quo_step[MEAN_W-1:0]);
                    div_quo_reg <= SUM_W'({crossing_count_reg, LEVEL_W'(0)});
                    div_rem_reg <= '0;
                    step_reg    <= '0;
                end
                else
                begin
                    div_quo_reg <= div_quo_step;
                    div_rem_reg <= div_rem_step;
                    step_reg    <= step_reg + STEP_W'(1);
                end
            end
            ST_DIV_RATE:
            begin
                if (last_step)
                begin
                    rate_reg   <= rate_sat;
                    sq_rem_reg <= '0;
                    root_reg   <= '0;
                    step_reg   <= '0;
                end
                else
                begin
                    div_quo_reg <= div_quo_step;
                    div_rem_reg <= div_rem_step;
                    step_reg    <= step_reg + STEP_W'(1);
                end
            end
            ST_SQRT:
            begin
                sq_rem_reg <= sq_rem_step;
                root_reg   <= root_step;
                rad_reg    <= {rad_reg[RAD_W-3:0], 2'b00};
                step_reg   <= step_reg + STEP_W'(1);
            end
            ST_OUT:
            begin
                if (out_load)
                begin
                    m_tdata_reg <= {peak_new, rate_reg, root_reg};
                end
            end
            default:
            begin
                step_reg <= '0;
            end
        endcase
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    a_start_clears_peak: assert property (@(posedge clk) disable iff (!rst_n)
        s_xfer && clip_start |=> peak_level_reg == '0)
        else $error("peak not cleared at start of clip");

    a_cross_le_count: assert property (@(posedge clk) disable iff (!rst_n)
        crossing_count_reg <= sample_count_reg)
        else $error("more crossings than samples in window");

    a_peak_ge_rms: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[OUT_W-1 -: LEVEL_W] >= m_tdata[LEVEL_W-1:0])
        else $error("peak below window rms");

    a_rms_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[LEVEL_W-1:0] <= LEVEL_W'(32768))
        else $error("rms above full scale");

    a_load_only_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("pending result overwritten");

endmodule
